// File: rtl/ppbm_pkg.sv
`timescale 1ns / 1ps
package ppbm_pkg;

   localparam int unsigned ChW = 5;
   localparam int unsigned PixW = 16;
   localparam logic [ChW-1:0] ChMax = 5'h1F;

   typedef enum logic [3:0] {
      MODE_COPY       = 4'd0,
      MODE_MULTIPLY   = 4'd1,
      MODE_GRAY       = 4'd2,
      MODE_LIGHTEN    = 4'd3,
      MODE_DARKEN     = 4'd4,
      MODE_DODGE      = 4'd5,
      MODE_SCREEN     = 4'd6,
      MODE_BURN       = 4'd7,
      MODE_DIFFERENCE = 4'd8,
      MODE_GRAY_STR   = 4'd9
   } mode_type;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_BLEND = 1'b1;

   localparam logic [1:0] CSR_EFFECT_MODE   = 2'd0;
   localparam logic [1:0] CSR_LAYOUT_565    = 2'd1;
   localparam logic [1:0] CSR_GRAY_STRENGTH = 2'd2;

   typedef logic [ChW-1:0] chan_type;

   // settings travelling with a pixel through the blend pipe
   typedef struct packed {
      logic [3:0] mode;
      logic       layout_565;
      logic [5:0] strength;
   } blend_cfg_type;

   // dodge reciprocal: ceil(2^16 / (32-s)), exact for numerators below 1024
   function automatic logic [16:0] dodge_recip(input chan_type s);
      logic [16:0] m;
      case (s)
         5'd0:  m = 17'd2048;
         5'd1:  m = 17'd2115;
         5'd2:  m = 17'd2185;
         5'd3:  m = 17'd2260;
         5'd4:  m = 17'd2341;
         5'd5:  m = 17'd2428;
         5'd6:  m = 17'd2521;
         5'd7:  m = 17'd2622;
         5'd8:  m = 17'd2731;
         5'd9:  m = 17'd2850;
         5'd10: m = 17'd2979;
         5'd11: m = 17'd3121;
         5'd12: m = 17'd3277;
         5'd13: m = 17'd3450;
         5'd14: m = 17'd3641;
         5'd15: m = 17'd3856;
         5'd16: m = 17'd4096;
         5'd17: m = 17'd4370;
         5'd18: m = 17'd4682;
         5'd19: m = 17'd5042;
         5'd20: m = 17'd5462;
         5'd21: m = 17'd5958;
         5'd22: m = 17'd6554;
         5'd23: m = 17'd7282;
         5'd24: m = 17'd8192;
         5'd25: m = 17'd9363;
         5'd26: m = 17'd10923;
         5'd27: m = 17'd13108;
         5'd28: m = 17'd16384;
         5'd29: m = 17'd21846;
         5'd30: m = 17'd32768;
         default: m = 17'd65536;
      endcase
      return m;
   endfunction

   // (r+g+b)/3 for sums up to 93
   function automatic chan_type div3(input logic [6:0] v);
      logic [13:0] p;
      p = {7'd0, v} * 14'd43;
      return p[11:7];
   endfunction

endpackage

// File: rtl/ppbm_if.sv
`timescale 1ns / 1ps
interface ppbm_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [7:0]  palette_index;
   logic [15:0] palette_color;
   logic [15:0] background;
   logic        span_end;
   modport source (output valid, operation, palette_index, palette_color, background,
      span_end, input ready);
   modport sink (input valid, operation, palette_index, palette_color, background,
      span_end, output ready);
endinterface

interface ppbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel;
   logic        span_last;
   modport source (output valid, pixel, span_last, input ready);
   modport sink (input valid, pixel, span_last, output ready);
endinterface

// File: rtl/palette_pixel_blend_modes_core.sv
`timescale 1ns / 1ps
// a blend beat's pixel is registered through the memory-read, split and blend stages before it is shown
// throughput: one beat per cycle while the output is not held, palette read and write each once a cycle
// writes update the palette at once; a blend right behind sees the new word
// reset clears pipe valids and settings (copy mode, 565 layout, strength 32)
// the palette is not cleared; unwritten entries read as anything
module palette_pixel_blend_modes_core
   import ppbm_pkg::*;
#(
   parameter int unsigned PALETTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_wdata,
   ppbm_req_if.sink    req,
   ppbm_rsp_if.source  rsp
);
   localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   logic [3:0] mode_ff;
   logic       layout_ff;
   logic [5:0] strength_ff;

   logic [15:0] pal_mem [PALETTE_DEPTH];

   logic          v1_ff, v2_ff, v3_ff;
   logic          hit1_ff;
   logic [15:0]   bg1_ff, bg2_ff, rd_ff, spr2_ff;
   logic          last1_ff, last2_ff, last3_ff;
   logic [15:0]   pix3_ff;
   blend_cfg_type cfg1_ff, cfg2_ff;
   logic [4:0]    avg2_ff;
   logic          in_range;
   logic          adv;
   logic          acc;
   logic [15:0]   pix_in;
   logic [15:0]   spr;

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_COPY;
         layout_ff <= 1'b1;
         strength_ff <= 6'd32;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EFFECT_MODE:   mode_ff <= csr_wdata[3:0];
            CSR_LAYOUT_565:    layout_ff <= csr_wdata[0];
            CSR_GRAY_STRENGTH: strength_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // whole pipe stalls together when the output is held
   assign adv = !v3_ff || rsp.ready;
   assign req.ready = adv;
   assign acc = req.valid && adv;
   assign in_range = {1'b0, req.palette_index} < 9'(PALETTE_DEPTH);

   // palette memory: one write and one read port
   always_ff @(posedge clock) begin
      if (acc && req.operation == OP_WRITE && in_range)
         pal_mem[req.palette_index[AW-1:0]] <= req.palette_color;
      if (adv)
         rd_ff <= pal_mem[req.palette_index[AW-1:0]];
   end

   // stage 1: memory read
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= acc && req.operation == OP_BLEND;
      end
      if (adv) begin
         hit1_ff <= in_range;
         bg1_ff <= req.background;
         last1_ff <= req.span_end;
         cfg1_ff <= '{mode: mode_ff, layout_565: layout_ff, strength: strength_ff};
      end
   end

   assign spr = hit1_ff ? rd_ff : 16'd0;

   // stage 2: channel split and average
   logic [3:0] sr1, sg1;
   logic [6:0] sum1;
   always_comb begin
      sr1 = cfg1_ff.layout_565 ? 4'd11 : 4'd10;
      sg1 = cfg1_ff.layout_565 ? 4'd6 : 4'd5;
      sum1 = 7'(5'(spr >> sr1)) + 7'(5'(spr >> sg1)) + 7'(spr[4:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         spr2_ff <= spr;
         bg2_ff <= bg1_ff;
         last2_ff <= last1_ff;
         cfg2_ff <= cfg1_ff;
         avg2_ff <= div3(sum1);
      end
   end

   // stage 3: per-channel blend
   logic [3:0] sr2, sg2;
   chan_type   rr, rg, rb;
   assign sr2 = cfg2_ff.layout_565 ? 4'd11 : 4'd10;
   assign sg2 = cfg2_ff.layout_565 ? 4'd6 : 4'd5;

   ppbm_chan u_r (.mode(cfg2_ff.mode), .strength(cfg2_ff.strength),
      .b(5'(bg2_ff >> sr2)), .s(5'(spr2_ff >> sr2)), .avg(avg2_ff), .res(rr));
   ppbm_chan u_g (.mode(cfg2_ff.mode), .strength(cfg2_ff.strength),
      .b(5'(bg2_ff >> sg2)), .s(5'(spr2_ff >> sg2)), .avg(avg2_ff), .res(rg));
   ppbm_chan u_b (.mode(cfg2_ff.mode), .strength(cfg2_ff.strength),
      .b(bg2_ff[4:0]), .s(spr2_ff[4:0]), .avg(avg2_ff), .res(rb));

   always_comb begin
      if (cfg2_ff.mode == MODE_COPY || cfg2_ff.mode > MODE_GRAY_STR)
         pix_in = spr2_ff;
      else
         pix_in = (16'(rr) << sr2) | (16'(rg) << sg2) | 16'(rb);
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
      if (adv) begin
         pix3_ff <= pix_in;
         last3_ff <= last2_ff;
      end
   end

   assign rsp.valid = v3_ff;
   assign rsp.pixel = pix3_ff;
   assign rsp.span_last = last3_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !rsp.ready |=> v3_ff && $stable(pix3_ff))
      else $error("output pixel changed while stalled");
   a_stall_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v2_ff) && $stable(v1_ff))
      else $error("pipe moved during stall");
   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      acc && req.operation == OP_WRITE |=> !v1_ff)
      else $error("palette write produced a pixel");
endmodule

// File: rtl/ppbm_chan.sv
`timescale 1ns / 1ps
module ppbm_chan
   import ppbm_pkg::*;
(
   input  logic [3:0] mode,
   input  logic [5:0] strength,
   input  chan_type   b,
   input  chan_type   s,
   input  chan_type   avg,
   output chan_type   res
);
   logic [9:0]  mul_p;
   logic [9:0]  burn_p;
   logic [4:0]  mx;
   logic [4:0]  mn;
   logic [9:0]  scr_p;
   logic [5:0]  scr;
   logic [16:0] recip;
   logic [21:0] dodge_p;
   logic signed [6:0]  diff;
   logic signed [13:0] gp;
   logic signed [13:0] gv;

   always_comb begin
      mul_p  = {5'd0, b} * {5'd0, s};
      burn_p = {5'd0, b} * (10'd32 - {5'd0, s});
      mx = (b > s) ? b : s;
      mn = (b > s) ? s : b;
      scr_p = (10'd32 - {5'd0, mx}) * {5'd0, mn};
      scr = {1'b0, scr_p[9:5]} + {1'b0, mx};
      // dodge: (b<<5)/(32-s) by reciprocal multiply, b*m>>11
      recip = dodge_recip(s);
      dodge_p = 22'(b) * 22'(recip);
      // gray strength: avg + floor((c-avg)*k/32), clamped
      diff = $signed({2'b0, s}) - $signed({2'b0, avg});
      gp = 14'(diff) * $signed({8'd0, strength});
      gv = $signed({9'd0, avg}) + (gp >>> 5);
      unique case (mode)
         MODE_MULTIPLY:   res = mul_p[9:5];
         MODE_GRAY:       res = avg;
         MODE_LIGHTEN:    res = mx;
         MODE_DARKEN:     res = mn;
         MODE_DODGE:      res = (dodge_p[21:11] > 11'd31) ? ChMax : dodge_p[15:11];
         MODE_SCREEN:     res = scr[5] ? ChMax : scr[4:0];
         MODE_BURN:       res = burn_p[9:5];
         MODE_DIFFERENCE: res = mx - mn;
         MODE_GRAY_STR:   res = gv < 0 ? 5'd0 : (gv > 31 ? ChMax : gv[4:0]);
         default:         res = s;
      endcase
   end
endmodule
